### hw/rtl/assert_macros.svh
// Assertion macros for the RTL of the urgency priority queue.
// Each macro expects a clock named clk and a synchronous reset named rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle assertion failed");

`endif

### hw/rtl/upq_pkg.sv
// Package for the urgency priority queue: sizes, record layout, command and status
// codes, and the microcode ROM that sequences the datapath. No dependencies.
package upq_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int TICKET_W = 5;
  localparam int CMP_W    = (CNT_W > TICKET_W) ? CNT_W : TICKET_W;
  localparam int SUM_W    = CMP_W + 1;

  typedef enum logic [1:0] {
    CMD_ENQUEUE = 2'd0,
    CMD_SORT    = 2'd1,
    CMD_DEQUEUE = 2'd2,
    CMD_UPDATE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_FULL       = 2'd1,
    ST_EMPTY      = 2'd2,
    ST_BAD_TICKET = 2'd3
  } status_t;

  typedef struct packed {
    logic [15:0] tag;
    logic [7:0]  age;
    logic [1:0]  sex;
    logic [1:0]  plan;
    logic [2:0]  urgency;
  } record_t;

  // Microcode addresses.
  typedef enum logic [4:0] {
    U_IDLE,
    U_DISP,
    U_ENQ_CHK,
    U_ENQ_WR,
    U_ENQ_FULL,
    U_DEQ_CHK,
    U_DEQ_OUT,
    U_UPD_CHK,
    U_UPD_TCK,
    U_UPD_WR,
    U_SORT_INIT,
    U_OUTER,
    U_LOAD_A,
    U_INNER,
    U_WRITE_I,
    U_SET_EMPTY,
    U_SET_BAD,
    U_DONE
  } step_t;

  // Datapath operations, one per control word.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,
    OP_CLR_RES,
    OP_ENQ_WRITE,
    OP_SET_FULL,
    OP_RD_HEAD,
    OP_DEQ_TAKE,
    OP_UPD_WRITE,
    OP_I_FROM_HEAD,
    OP_RD_I,
    OP_LOAD_A,
    OP_CMP_SWAP,
    OP_WRITE_I,
    OP_SET_EMPTY,
    OP_SET_BAD,
    OP_EMIT
  } op_t;

  // Branch conditions tested by the sequencer.
  typedef enum logic [3:0] {
    C_ALWAYS,
    C_IN_ACC,
    C_OUT_FREE,
    C_FULL,
    C_EMPTY,
    C_BAD_TICKET,
    C_OUTER_END,
    C_INNER_END,
    C_CMD
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t on_true;
    step_t on_false;
  } uword_t;

  // Control store: one word per step.
  function automatic uword_t ucode(input step_t step);
    uword_t w;
    case (step)
      U_IDLE:      w = '{op: OP_LATCH,       cond: C_IN_ACC,     on_true: U_DISP,
                         on_false: U_IDLE};
      U_DISP:      w = '{op: OP_CLR_RES,     cond: C_CMD,        on_true: U_IDLE,
                         on_false: U_IDLE};
      U_ENQ_CHK:   w = '{op: OP_NONE,        cond: C_FULL,       on_true: U_ENQ_FULL,
                         on_false: U_ENQ_WR};
      U_ENQ_WR:    w = '{op: OP_ENQ_WRITE,   cond: C_ALWAYS,     on_true: U_DONE,
                         on_false: U_DONE};
      U_ENQ_FULL:  w = '{op: OP_SET_FULL,    cond: C_ALWAYS,     on_true: U_DONE,
                         on_false: U_DONE};
      U_DEQ_CHK:   w = '{op: OP_RD_HEAD,     cond: C_EMPTY,      on_true: U_SET_EMPTY,
                         on_false: U_DEQ_OUT};
      U_DEQ_OUT:   w = '{op: OP_DEQ_TAKE,    cond: C_ALWAYS,     on_true: U_DONE,
                         on_false: U_DONE};
      U_UPD_CHK:   w = '{op: OP_NONE,        cond: C_EMPTY,      on_true: U_SET_EMPTY,
                         on_false: U_UPD_TCK};
      U_UPD_TCK:   w = '{op: OP_NONE,        cond: C_BAD_TICKET, on_true: U_SET_BAD,
                         on_false: U_UPD_WR};
      U_UPD_WR:    w = '{op: OP_UPD_WRITE,   cond: C_ALWAYS,     on_true: U_SORT_INIT,
                         on_false: U_SORT_INIT};
      U_SORT_INIT: w = '{op: OP_I_FROM_HEAD, cond: C_ALWAYS,     on_true: U_OUTER,
                         on_false: U_OUTER};
      U_OUTER:     w = '{op: OP_RD_I,        cond: C_OUTER_END,  on_true: U_DONE,
                         on_false: U_LOAD_A};
      U_LOAD_A:    w = '{op: OP_LOAD_A,      cond: C_ALWAYS,     on_true: U_INNER,
                         on_false: U_INNER};
      U_INNER:     w = '{op: OP_CMP_SWAP,    cond: C_INNER_END,  on_true: U_WRITE_I,
                         on_false: U_INNER};
      U_WRITE_I:   w = '{op: OP_WRITE_I,     cond: C_ALWAYS,     on_true: U_OUTER,
                         on_false: U_OUTER};
      U_SET_EMPTY: w = '{op: OP_SET_EMPTY,   cond: C_ALWAYS,     on_true: U_DONE,
                         on_false: U_DONE};
      U_SET_BAD:   w = '{op: OP_SET_BAD,     cond: C_ALWAYS,     on_true: U_DONE,
                         on_false: U_DONE};
      U_DONE:      w = '{op: OP_EMIT,        cond: C_OUT_FREE,   on_true: U_IDLE,
                         on_false: U_DONE};
      default:     w = '{op: OP_NONE,        cond: C_ALWAYS,     on_true: U_IDLE,
                         on_false: U_IDLE};
    endcase
    return w;
  endfunction

  // Entry point of each command's routine.
  function automatic step_t cmd_entry(input cmd_t c);
    step_t s;
    case (c)
      CMD_ENQUEUE: s = U_ENQ_CHK;
      CMD_SORT:    s = U_SORT_INIT;
      CMD_DEQUEUE: s = U_DEQ_CHK;
      CMD_UPDATE:  s = U_UPD_CHK;
      default:     s = U_IDLE;
    endcase
    return s;
  endfunction

endpackage

### hw/rtl/urgency_priority_queue.sv
// Urgency priority queue top level: microcoded sequencer, record memory, result register.
// Depends on upq_pkg and assert_macros.svh. One transaction is worked on at a time.
// A new transaction is taken only after the last one's result has been loaded into the output
// register, later if that waits on out_stall. Reset clears head, tail, sequencer and out_valid,
// not the memory.
`include "assert_macros.svh"

module urgency_priority_queue (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  cmd,
  input  logic [4:0]  ticket_number,
  input  logic [15:0] patient_tag,
  input  logic [7:0]  age_years,
  input  logic [1:0]  sex_code,
  input  logic [1:0]  plan_code,
  input  logic [2:0]  urgency_level,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [4:0]  out_ticket,
  output logic [15:0] out_tag,
  output logic [7:0]  out_age,
  output logic [1:0]  out_sex,
  output logic [1:0]  out_plan,
  output logic [2:0]  out_urgency
);

  // Sequencer state.
  upq_pkg::step_t  upc, upc_next;
  upq_pkg::uword_t uw;

  // Queue pointers and sort indexes.
  logic [upq_pkg::CNT_W-1:0] head, head_next;
  logic [upq_pkg::CNT_W-1:0] tail, tail_next;
  logic [upq_pkg::CNT_W-1:0] i_idx, i_idx_next;
  logic [upq_pkg::CNT_W-1:0] j_idx, j_idx_next;

  // Latched transaction and working records.
  upq_pkg::cmd_t             cmd_r, cmd_r_next;
  logic [upq_pkg::TICKET_W-1:0] ticket_r, ticket_r_next;
  upq_pkg::record_t          rec_in, rec_in_next;
  upq_pkg::record_t          cur, cur_next;

  // Pending result.
  upq_pkg::status_t          res_status, res_status_next;
  logic [upq_pkg::TICKET_W-1:0] res_ticket, res_ticket_next;
  upq_pkg::record_t          res_rec, res_rec_next;

  // Output register.
  logic                      out_valid_next;
  upq_pkg::status_t          out_status_q, out_status_next;
  logic [upq_pkg::TICKET_W-1:0] out_ticket_q, out_ticket_next;
  upq_pkg::record_t          out_rec_q, out_rec_next;

  // Record memory ports.
  upq_pkg::record_t          mem [upq_pkg::CAPACITY];
  upq_pkg::record_t          rd_data;
  logic                      mem_we;
  logic [upq_pkg::IDX_W-1:0] mem_waddr;
  logic [upq_pkg::IDX_W-1:0] mem_raddr;
  upq_pkg::record_t          mem_wdata;

  // Handshakes and derived arithmetic.
  logic                      in_fire;
  logic                      out_free;
  logic [upq_pkg::SUM_W-1:0] head_inc, tail_inc, i_inc, j_inc;
  logic [upq_pkg::SUM_W-1:0] tail_ext;
  logic [upq_pkg::SUM_W-1:0] ticket_ext;
  logic [upq_pkg::SUM_W-1:0] ticket_dec;
  logic                      cond_hit;

  assign in_stall = (upc != upq_pkg::U_IDLE);
  assign in_fire  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  assign head_inc   = upq_pkg::SUM_W'(head) + upq_pkg::SUM_W'(1);
  assign tail_inc   = upq_pkg::SUM_W'(tail) + upq_pkg::SUM_W'(1);
  assign i_inc      = upq_pkg::SUM_W'(i_idx) + upq_pkg::SUM_W'(1);
  assign j_inc      = upq_pkg::SUM_W'(j_idx) + upq_pkg::SUM_W'(1);
  assign tail_ext   = upq_pkg::SUM_W'(tail);
  assign ticket_ext = upq_pkg::SUM_W'(ticket_r);
  assign ticket_dec = ticket_ext - upq_pkg::SUM_W'(1);

  assign uw = upq_pkg::ucode(upc);

  // Branch condition selected by the current control word.
  always_comb begin
    case (uw.cond)
      upq_pkg::C_ALWAYS:     cond_hit = 1'b1;
      upq_pkg::C_IN_ACC:     cond_hit = in_fire;
      upq_pkg::C_OUT_FREE:   cond_hit = out_free;
      upq_pkg::C_FULL:       cond_hit = tail_ext >= upq_pkg::SUM_W'(upq_pkg::CAPACITY);
      upq_pkg::C_EMPTY:      cond_hit = head >= tail;
      upq_pkg::C_BAD_TICKET: cond_hit = (ticket_ext == '0) || (ticket_ext > tail_ext);
      upq_pkg::C_OUTER_END:  cond_hit = i_inc >= tail_ext;
      upq_pkg::C_INNER_END:  cond_hit = j_inc >= tail_ext;
      default:               cond_hit = 1'b0;
    endcase
  end

  // Next microcode address.
  always_comb begin
    if (uw.cond == upq_pkg::C_CMD) begin
      upc_next = upq_pkg::cmd_entry(cmd_r);
    end else if (cond_hit) begin
      upc_next = uw.on_true;
    end else begin
      upc_next = uw.on_false;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= upq_pkg::U_IDLE;
    end else begin
      upc <= upc_next;
    end
  end

  // Datapath controlled by the operation field.
  always_comb begin
    head_next       = head;
    tail_next       = tail;
    i_idx_next      = i_idx;
    j_idx_next      = j_idx;
    cmd_r_next      = cmd_r;
    ticket_r_next   = ticket_r;
    rec_in_next     = rec_in;
    cur_next        = cur;
    res_status_next = res_status;
    res_ticket_next = res_ticket;
    res_rec_next    = res_rec;
    out_valid_next  = out_valid && out_stall;
    out_status_next = out_status_q;
    out_ticket_next = out_ticket_q;
    out_rec_next    = out_rec_q;
    mem_we          = 1'b0;
    mem_waddr       = '0;
    mem_wdata       = rec_in;
    mem_raddr       = '0;
    case (uw.op)
      upq_pkg::OP_LATCH: begin
        if (in_fire) begin
          cmd_r_next    = upq_pkg::cmd_t'(cmd);
          ticket_r_next = ticket_number;
          rec_in_next   = '{tag: patient_tag, age: age_years, sex: sex_code,
                            plan: plan_code, urgency: urgency_level};
        end
      end
      upq_pkg::OP_CLR_RES: begin
        res_status_next = upq_pkg::ST_OK;
        res_ticket_next = '0;
        res_rec_next    = '0;
      end
      upq_pkg::OP_ENQ_WRITE: begin
        mem_we          = 1'b1;
        mem_waddr       = tail[upq_pkg::IDX_W-1:0];
        res_ticket_next = tail_inc[upq_pkg::TICKET_W-1:0];
        tail_next       = tail_inc[upq_pkg::CNT_W-1:0];
      end
      upq_pkg::OP_SET_FULL: begin
        res_status_next = upq_pkg::ST_FULL;
      end
      upq_pkg::OP_RD_HEAD: begin
        mem_raddr = head[upq_pkg::IDX_W-1:0];
      end
      upq_pkg::OP_DEQ_TAKE: begin
        res_rec_next    = rd_data;
        res_ticket_next = head_inc[upq_pkg::TICKET_W-1:0];
        head_next       = head_inc[upq_pkg::CNT_W-1:0];
      end
      upq_pkg::OP_UPD_WRITE: begin
        mem_we          = 1'b1;
        mem_waddr       = ticket_dec[upq_pkg::IDX_W-1:0];
        res_ticket_next = ticket_r;
      end
      upq_pkg::OP_I_FROM_HEAD: begin
        i_idx_next = head;
      end
      upq_pkg::OP_RD_I: begin
        mem_raddr  = i_idx[upq_pkg::IDX_W-1:0];
        j_idx_next = i_inc[upq_pkg::CNT_W-1:0];
      end
      upq_pkg::OP_LOAD_A: begin
        cur_next  = rd_data;
        mem_raddr = j_idx[upq_pkg::IDX_W-1:0];
      end
      upq_pkg::OP_CMP_SWAP: begin
        // Record j sits in rd_data; exchange with the running slot-i record.
        if (cur.urgency < rd_data.urgency) begin
          mem_we    = 1'b1;
          mem_waddr = j_idx[upq_pkg::IDX_W-1:0];
          mem_wdata = cur;
          cur_next  = rd_data;
        end
        j_idx_next = j_inc[upq_pkg::CNT_W-1:0];
        mem_raddr  = j_inc[upq_pkg::IDX_W-1:0];
      end
      upq_pkg::OP_WRITE_I: begin
        mem_we     = 1'b1;
        mem_waddr  = i_idx[upq_pkg::IDX_W-1:0];
        mem_wdata  = cur;
        i_idx_next = i_inc[upq_pkg::CNT_W-1:0];
      end
      upq_pkg::OP_SET_EMPTY: begin
        res_status_next = upq_pkg::ST_EMPTY;
      end
      upq_pkg::OP_SET_BAD: begin
        res_status_next = upq_pkg::ST_BAD_TICKET;
      end
      upq_pkg::OP_EMIT: begin
        if (out_free) begin
          out_valid_next  = 1'b1;
          out_status_next = res_status;
          out_ticket_next = res_ticket;
          out_rec_next    = res_rec;
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      tail      <= '0;
      out_valid <= 1'b0;
    end else begin
      head      <= head_next;
      tail      <= tail_next;
      out_valid <= out_valid_next;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    i_idx        <= i_idx_next;
    j_idx        <= j_idx_next;
    cmd_r        <= cmd_r_next;
    ticket_r     <= ticket_r_next;
    rec_in       <= rec_in_next;
    cur          <= cur_next;
    res_status   <= res_status_next;
    res_ticket   <= res_ticket_next;
    res_rec      <= res_rec_next;
    out_status_q <= out_status_next;
    out_ticket_q <= out_ticket_next;
    out_rec_q    <= out_rec_next;
  end

  // Record memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[mem_raddr];
  end

  assign status      = out_status_q;
  assign out_ticket  = out_ticket_q;
  assign out_tag     = out_rec_q.tag;
  assign out_age     = out_rec_q.age;
  assign out_sex     = out_rec_q.sex;
  assign out_plan    = out_rec_q.plan;
  assign out_urgency = out_rec_q.urgency;

  // Checks on the sequencer and pointer bookkeeping.
  `ASSERT_SAME(a_head_le_tail, 1'b1, head <= tail)
  `ASSERT_SAME(a_tail_le_cap, 1'b1, upq_pkg::SUM_W'(tail) <= upq_pkg::SUM_W'(upq_pkg::CAPACITY))
  `ASSERT_NEXT(a_accept_dispatch, in_fire, upc == upq_pkg::U_DISP)
  `ASSERT_SAME(a_inner_in_range, upc == upq_pkg::U_INNER, j_idx < tail && i_idx < j_idx)

endmodule

### tb/tb_urgency_priority_queue.sv
// Self-checking testbench for urgency_priority_queue: a directed table, then random traffic.
// Depends on upq_pkg for the command, status and record types; results are checked in order
// against a behavioral copy of the linear, exchange-sorted triage store or the table's typed values.
module tb_urgency_priority_queue;
  import upq_pkg::*;

  localparam int N_RANDOM    = 530;
  localparam int N_DIRECTED  = 21;
  localparam int N_TOTAL     = N_DIRECTED + N_RANDOM;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 200;

  typedef struct packed {
    status_t     status;
    logic [4:0]  ticket;
    record_t     rec;
  } triage_result_t;

  typedef struct packed {
    cmd_t        op;
    logic [4:0]  ticket;
    record_t     rec;
    logic        typed;
    status_t     want_status;
    logic [4:0]  want_ticket;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  cmd = '0;
  logic [4:0]  ticket_number = '0;
  logic [15:0] patient_tag = '0;
  logic [7:0]  age_years = '0;
  logic [1:0]  sex_code = '0;
  logic [1:0]  plan_code = '0;
  logic [2:0]  urgency_level = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  status;
  logic [4:0]  out_ticket;
  logic [15:0] out_tag;
  logic [7:0]  out_age;
  logic [1:0]  out_sex;
  logic [1:0]  out_plan;
  logic [2:0]  out_urgency;

  // Predictor state: the record slots and the two queue pointers.
  record_t ward_slots [CAPACITY];
  int      ward_head = 0;
  int      ward_tail = 0;

  triage_result_t pending_results [$];
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int items_sent = 0;
  int results_seen = 0;
  int failures = 0;
  int cycle_count = 0;
  int status_seen [4] = '{0, 0, 0, 0};

  // Directed table: typed expectations only where they are obvious.
  stim_row_t directed [N_DIRECTED] = '{
    '{CMD_DEQUEUE, 5'd0,  31'd0,                                 1'b1, ST_EMPTY,      5'd0},
    '{CMD_UPDATE,  5'd1,  {16'h0101, 8'd20, 2'd1, 2'd1, 3'd2},   1'b1, ST_EMPTY,      5'd0},
    '{CMD_SORT,    5'd0,  31'd0,                                 1'b1, ST_OK,         5'd0},
    '{CMD_ENQUEUE, 5'd0,  {16'hFFFF, 8'd255, 2'd3, 2'd3, 3'd7},  1'b1, ST_OK,         5'd1},
    '{CMD_ENQUEUE, 5'd31, {16'h0000, 8'd0, 2'd0, 2'd0, 3'd0},    1'b1, ST_OK,         5'd2},
    '{CMD_ENQUEUE, 5'd0,  {16'h1234, 8'd40, 2'd1, 2'd2, 3'd3},   1'b1, ST_OK,         5'd3},
    '{CMD_ENQUEUE, 5'd0,  {16'hABCD, 8'd7, 2'd2, 2'd1, 3'd5},    1'b1, ST_OK,         5'd4},
    '{CMD_UPDATE,  5'd0,  {16'h5A5A, 8'd33, 2'd1, 2'd1, 3'd4},   1'b1, ST_BAD_TICKET, 5'd0},
    '{CMD_UPDATE,  5'd5,  {16'h5A5A, 8'd33, 2'd1, 2'd1, 3'd4},   1'b1, ST_BAD_TICKET, 5'd0},
    '{CMD_UPDATE,  5'd31, {16'h5A5A, 8'd33, 2'd1, 2'd1, 3'd4},   1'b1, ST_BAD_TICKET, 5'd0},
    '{CMD_SORT,    5'd0,  31'd0,                                 1'b1, ST_OK,         5'd0},
    '{CMD_DEQUEUE, 5'd0,  31'd0,                                 1'b0, ST_OK,         5'd0},
    '{CMD_UPDATE,  5'd1,  {16'h00AA, 8'd90, 2'd2, 2'd2, 3'd1},   1'b1, ST_OK,         5'd1},
    '{CMD_DEQUEUE, 5'd0,  31'd0,                                 1'b0, ST_OK,         5'd0},
    '{CMD_UPDATE,  5'd4,  {16'h7777, 8'd61, 2'd1, 2'd2, 3'd6},   1'b1, ST_OK,         5'd4},
    '{CMD_DEQUEUE, 5'd0,  31'd0,                                 1'b0, ST_OK,         5'd0},
    '{CMD_ENQUEUE, 5'd0,  {16'h5555, 8'd12, 2'd2, 2'd1, 3'd1},   1'b1, ST_OK,         5'd5},
    '{CMD_ENQUEUE, 5'd0,  {16'h6666, 8'd13, 2'd1, 2'd2, 3'd1},   1'b1, ST_OK,         5'd6},
    '{CMD_SORT,    5'd0,  31'd0,                                 1'b0, ST_OK,         5'd0},
    '{CMD_DEQUEUE, 5'd0,  31'd0,                                 1'b0, ST_OK,         5'd0},
    '{CMD_UPDATE,  5'd3,  {16'hC0DE, 8'd80, 2'd2, 2'd2, 3'd2},   1'b1, ST_OK,         5'd3}
  };

  urgency_priority_queue dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .cmd           (cmd),
    .ticket_number (ticket_number),
    .patient_tag   (patient_tag),
    .age_years     (age_years),
    .sex_code      (sex_code),
    .plan_code     (plan_code),
    .urgency_level (urgency_level),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .out_ticket    (out_ticket),
    .out_tag       (out_tag),
    .out_age       (out_age),
    .out_sex       (out_sex),
    .out_plan      (out_plan),
    .out_urgency   (out_urgency)
  );

  // Free-running clock.
  initial begin
    forever #5 clk = ~clk;
  end

  // Exchange sort of the live range, highest urgency first.
  function automatic void reorder_by_urgency();
    record_t swap_tmp;
    for (int i = ward_head; i + 1 < ward_tail; i++) begin
      for (int j = i + 1; j < ward_tail; j++) begin
        if (ward_slots[i].urgency < ward_slots[j].urgency) begin
          swap_tmp      = ward_slots[i];
          ward_slots[i] = ward_slots[j];
          ward_slots[j] = swap_tmp;
        end
      end
    end
  endfunction

  // Applies one command to the predictor state and returns the result it causes.
  function automatic triage_result_t triage_apply(input cmd_t op, input logic [4:0] tk,
                                                  input record_t r);
    triage_result_t res;
    res = '{status: ST_OK, ticket: 5'd0, rec: 31'd0};
    case (op)
      CMD_ENQUEUE: begin
        if (ward_tail >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          ward_slots[ward_tail] = r;
          ward_tail++;
          res.ticket = 5'(ward_tail);
        end
      end
      CMD_SORT: begin
        reorder_by_urgency();
      end
      CMD_DEQUEUE: begin
        if (ward_head >= ward_tail) begin
          res.status = ST_EMPTY;
        end else begin
          res.rec = ward_slots[ward_head];
          ward_head++;
          res.ticket = 5'(ward_head);
        end
      end
      CMD_UPDATE: begin
        if (ward_head >= ward_tail) begin
          res.status = ST_EMPTY;
        end else if (tk == 5'd0 || int'(tk) > ward_tail) begin
          res.status = ST_BAD_TICKET;
        end else begin
          ward_slots[int'(tk) - 1] = r;
          res.ticket = tk;
          reorder_by_urgency();
        end
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  // Drives one transaction, waits for it to be taken and records its expected result.
  task automatic send_item(input stim_row_t row);
    triage_result_t predicted;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    cmd           <= row.op;
    ticket_number <= row.ticket;
    patient_tag   <= row.rec.tag;
    age_years     <= row.rec.age;
    sex_code      <= row.rec.sex;
    plan_code     <= row.rec.plan;
    urgency_level <= row.rec.urgency;
    do @(posedge clk); while (in_stall);
    predicted = triage_apply(row.op, row.ticket, row.rec);
    if (row.typed) begin
      predicted = '{status: row.want_status, ticket: row.want_ticket, rec: 31'd0};
    end
    pending_results.push_back(predicted);
    items_sent++;
  endtask

  // Random transaction: dequeues are kept rare so the queue stays live, then it is drained.
  function automatic stim_row_t random_row(input int left);
    stim_row_t row;
    int roll;
    roll = $urandom_range(0, 99);
    row = '0;
    if (left <= 40) begin
      row.op = (roll < 50) ? CMD_DEQUEUE : (roll < 70) ? CMD_UPDATE :
               (roll < 85) ? CMD_SORT : CMD_ENQUEUE;
    end else begin
      row.op = (roll < 2) ? CMD_DEQUEUE : (roll < 18) ? CMD_ENQUEUE :
               (roll < 38) ? CMD_SORT : CMD_UPDATE;
    end
    if (ward_tail > 0 && $urandom_range(0, 99) < 85) begin
      row.ticket = 5'($urandom_range(1, ward_tail));
    end else begin
      row.ticket = 5'($urandom_range(0, 31));
    end
    row.rec.tag     = 16'($urandom);
    row.rec.age     = 8'($urandom);
    row.rec.sex     = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(0, 3))
                                                  : 2'($urandom_range(1, 2));
    row.rec.plan    = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(0, 3))
                                                  : 2'($urandom_range(1, 2));
    row.rec.urgency = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7))
                                                  : 3'($urandom_range(1, 5));
    return row;
  endfunction

  // Idling pattern follows the share of transactions sent so far.
  task automatic set_idling(input int idx);
    if (idx < N_TOTAL / 3) begin
      tx_idle_pct = 33;
      rx_idle_pct = 54;
    end else if (idx < 2 * N_TOTAL / 3) begin
      tx_idle_pct = 54;
      rx_idle_pct = 33;
    end else begin
      tx_idle_pct = 0;
      rx_idle_pct = 0;
    end
  endtask

  // Receiver back-pressure.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
  end

  // Result checker: every accepted result against the oldest expectation.
  always @(posedge clk) begin : result_check
    triage_result_t want;
    bit bad;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      status_seen[status]++;
      if (pending_results.size() == 0) begin
        failures++;
        if (failures <= 10) begin
          $display("Unexpected result: status=%0d ticket=%0d tag=%h", status, out_ticket,
                   out_tag);
        end
      end else begin
        want = pending_results.pop_front();
        bad = (status !== want.status) || (out_ticket !== want.ticket) ||
              (out_tag !== want.rec.tag) || (out_age !== want.rec.age) ||
              (out_sex !== want.rec.sex) || (out_plan !== want.rec.plan) ||
              (out_urgency !== want.rec.urgency);
        if (bad) begin
          failures++;
          if (failures <= 10) begin
            $display("Result %0d differs: expected st=%0d tk=%0d tag=%h age=%0d sex=%0d",
                     results_seen, want.status, want.ticket, want.rec.tag, want.rec.age,
                     want.rec.sex);
            $display("  plan=%0d urg=%0d; got st=%0d tk=%0d tag=%h age=%0d sex=%0d",
                     want.rec.plan, want.rec.urgency, status, out_ticket, out_tag, out_age,
                     out_sex);
            $display("  plan=%0d urg=%0d", out_plan, out_urgency);
          end
        end
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding", cycle_count,
               pending_results.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Main sequence: reset, directed table, random traffic, drain and verdict.
  initial begin
    stim_row_t row;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int k = 0; k < N_DIRECTED; k++) begin
      set_idling(k);
      send_item(directed[k]);
    end

    for (int k = 0; k < N_RANDOM; k++) begin
      set_idling(N_DIRECTED + k);
      row = random_row(N_RANDOM - k);
      send_item(row);
    end
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Sent %0d transactions, checked %0d results in %0d cycles.", items_sent,
             results_seen, cycle_count);
    $display("Status counts: ok %0d, full %0d, empty %0d, bad ticket %0d.",
             status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_EMPTY],
             status_seen[ST_BAD_TICKET]);
    if (failures == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d failing results, %0d expectations left", failures,
               pending_results.size());
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/upq_pkg.sv
hw/rtl/urgency_priority_queue.sv
tb/tb_urgency_priority_queue.sv
